>>> hw/rtl/rba_pkg.sv
// rba_pkg: word types, mode and register codes for the radial bin accumulator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rba_pkg;

   localparam logic [2:0] MODE_SAMPLE   = 3'd0;
   localparam logic [2:0] MODE_END_SNAP = 3'd1;
   localparam logic [2:0] MODE_READ     = 3'd2;
   localparam logic [2:0] MODE_LOAD_WGT = 3'd3;
   localparam logic [2:0] MODE_CLEAR    = 3'd4;

   localparam logic [1:0] CFG_GRID_SIZE  = 2'd0;
   localparam logic [1:0] CFG_ROW_OFFSET = 2'd1;
   localparam logic [1:0] CFG_INV_SCALE  = 2'd2;
   localparam logic [1:0] CFG_BIN_COUNT  = 2'd3;

   localparam int R2_W       = 24;
   localparam int ROOT_W     = 12;
   localparam int ROOT_STEPS = 12;
   localparam int SEL_W      = 13;

   localparam logic signed [63:0] OUT_MAX_W = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] OUT_MIN_W = -64'sh0000_8000_0000_0000;

   typedef struct packed {
      logic [2:0]         mode;
      logic [9:0]         col_index;
      logic [9:0]         row_index;
      logic signed [31:0] sample_value;
      logic [8:0]         bin_select;
      logic [24:0]        weight_value;
   } req_word_type;

   typedef struct packed {
      logic signed [47:0] bin_sum;
      logic [15:0]        snapshot_count;
      logic               sample_binned;
      logic               saturated;
   } rsp_word_type;

endpackage
`default_nettype wire

>>> hw/rtl/rba_isqrt.sv
// rba_isqrt: iterative integer square root, two radicand bits per cycle,
// rounded to nearest; depends on rba_pkg
`timescale 1ns / 1ps
`default_nettype none
module rba_isqrt import rba_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [R2_W-1:0]   r2,
   output logic                   done,
   output logic [ROOT_W-1:0]      bin
);

   logic              busy_ff;
   logic [3:0]        cnt_ff;
   logic [R2_W-1:0]   src_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [15:0]       rem_ff;
   logic              done_ff;
   logic [ROOT_W-1:0] bin_ff;

   logic [15:0]       cur;
   logic [15:0]       trial;
   logic              ge;
   logic [ROOT_W-1:0] root_in;
   logic [15:0]       rem_in;

   always_comb begin
      cur     = {rem_ff[13:0], src_ff[R2_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = (cur >= trial);
      root_in = {root_ff[ROOT_W-2:0], ge};
      rem_in  = ge ? (cur - trial) : cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            src_ff  <= r2;
            root_ff <= '0;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            src_ff  <= {src_ff[R2_W-3:0], 2'b00};
            root_ff <= root_in;
            rem_ff  <= rem_in;
            cnt_ff  <= cnt_ff + 4'd1;
            if (cnt_ff == 4'(ROOT_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               bin_ff  <= root_in + ROOT_W'(rem_in > {4'b0000, root_in});
            end
         end
      end
   end

   assign done = done_ff;
   assign bin  = bin_ff;

endmodule
`default_nettype wire

>>> hw/rtl/rba_scale.sv
// rba_scale: Q1.24 scaling of an accumulator with rounding and saturation,
// two partial products through one shared 32x25 multiplier; uses rba_pkg
`timescale 1ns / 1ps
`default_nettype none
module rba_scale import rba_pkg::*; #(
   parameter int ACC_BITS = 48
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic signed [ACC_BITS-1:0] a,
   input  wire logic [24:0]                f,
   output logic                            done,
   output logic signed [ACC_BITS-1:0]      result,
   output logic                            sat
);

   localparam logic [1:0] SC_IDLE = 2'd0;
   localparam logic [1:0] SC_HI   = 2'd1;
   localparam logic [1:0] SC_LO   = 2'd2;
   localparam logic [1:0] SC_FIN  = 2'd3;

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   logic [1:0]                 state_ff;
   logic                       neg_ff;
   logic [63:0]                mag_ff;
   logic [24:0]                f_ff;
   logic [56:0]                prod_ff;
   logic [56:0]                hi_ff;
   logic                       done_ff;
   logic                       sat_ff;
   logic signed [ACC_BITS-1:0] result_ff;

   logic signed [63:0]         a64;
   logic [31:0]                mul_a;
   logic [56:0]                prod_in;
   logic [33:0]                rnd;
   logic [65:0]                r;
   logic [65:0]                nr;
   logic [65:0]                lim;
   logic                       ovf;

   always_comb begin
      a64     = 64'(a);
      mul_a   = (state_ff == SC_HI) ? mag_ff[63:32] : mag_ff[31:0];
      prod_in = 57'(mul_a) * 57'(f_ff);
      rnd     = 34'(({1'b0, prod_ff} + 58'(24'h80_0000)) >> 24);
      r       = {1'b0, hi_ff, 8'h00} + 66'(rnd);
      nr      = 66'd0 - r;
      lim     = (66'd1 << (ACC_BITS - 1)) - 66'(!neg_ff);
      ovf     = (hi_ff[56:55] != 2'b00) || (r > lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            SC_IDLE: begin
               if (start) begin
                  neg_ff   <= a[ACC_BITS-1];
                  mag_ff   <= a[ACC_BITS-1] ? (64'd0 - a64) : a64;
                  f_ff     <= f;
                  state_ff <= SC_HI;
               end
            end
            SC_HI: begin
               prod_ff  <= prod_in;
               state_ff <= SC_LO;
            end
            SC_LO: begin
               hi_ff    <= prod_ff;
               prod_ff  <= prod_in;
               state_ff <= SC_FIN;
            end
            SC_FIN: begin
               done_ff <= 1'b1;
               sat_ff  <= ovf;
               if (ovf) begin
                  result_ff <= neg_ff ? ACC_MIN : ACC_MAX;
               end else begin
                  result_ff <= neg_ff ? nr[ACC_BITS-1:0] : r[ACC_BITS-1:0];
               end
               state_ff <= SC_IDLE;
            end
            default: state_ff <= SC_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;
   assign sat    = sat_ff;

endmodule
`default_nettype wire

>>> hw/rtl/radial_bin_accumulator.sv
// radial_bin_accumulator: radial binning of grid samples with snapshot scaling
// uses rba_pkg, rba_isqrt and rba_scale
// one word at a time: a new word is accepted only after the response to the
// previous word is registered
// reset: synchronous; a clearing pass over all MAX_BINS bins zeroes them, no
// word is accepted meanwhile; configuration writes are taken at any time
`timescale 1ns / 1ps
`default_nettype none
module radial_bin_accumulator import rba_pkg::*; #(
   parameter int MAX_BINS = 512,
   parameter int ACC_BITS = 48
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_wr_en,
   input  wire logic [1:0]   csr_index,
   input  wire logic [24:0]  csr_wdata
);

   localparam int IDX_W = $clog2(MAX_BINS);
   localparam int SW    = ACC_BITS + 2;
   localparam logic signed [SW-1:0] SUM_MAX = {3'b000, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] SUM_MIN = {3'b111, {(ACC_BITS-1){1'b0}}};

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FOLD  = 4'd1;
   localparam logic [3:0] ST_ROOT  = 4'd2;
   localparam logic [3:0] ST_SRD   = 4'd3;
   localparam logic [3:0] ST_SADD  = 4'd4;
   localparam logic [3:0] ST_SWRD  = 4'd5;
   localparam logic [3:0] ST_SWA   = 4'd6;
   localparam logic [3:0] ST_SWB   = 4'd7;
   localparam logic [3:0] ST_SWC   = 4'd8;
   localparam logic [3:0] ST_SWD   = 4'd9;
   localparam logic [3:0] ST_SWWR  = 4'd10;
   localparam logic [3:0] ST_CLR   = 4'd11;
   localparam logic [3:0] ST_READ1 = 4'd12;
   localparam logic [3:0] ST_READ2 = 4'd13;
   localparam logic [3:0] ST_RESP  = 4'd14;

   function automatic logic signed [ACC_BITS-1:0] sat_add(
      input  logic signed [ACC_BITS-1:0] x,
      input  logic signed [ACC_BITS:0]   y,
      output logic                       ovf
   );
      logic signed [SW-1:0] s;
      s   = SW'(x) + SW'(y);
      ovf = (s > SUM_MAX) || (s < SUM_MIN);
      if (s > SUM_MAX) begin
         sat_add = SUM_MAX[ACC_BITS-1:0];
      end else if (s < SUM_MIN) begin
         sat_add = SUM_MIN[ACC_BITS-1:0];
      end else begin
         sat_add = s[ACC_BITS-1:0];
      end
   endfunction

   // configuration
   logic [10:0] grid_ff;
   logic [9:0]  offset_ff;
   logic [24:0] inv_scale_ff;
   logic [9:0]  bin_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff      <= 11'd1024;
         offset_ff    <= 10'd0;
         inv_scale_ff <= 25'd16384;
         bin_count_ff <= 10'd512;
      end else if (csr_wr_en) begin
         case (csr_index)
            CFG_GRID_SIZE:  grid_ff      <= csr_wdata[10:0];
            CFG_ROW_OFFSET: offset_ff    <= csr_wdata[9:0];
            CFG_INV_SCALE:  inv_scale_ff <= csr_wdata;
            CFG_BIN_COUNT:  bin_count_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // control and working registers
   logic [3:0]                 state_ff;
   logic [IDX_W-1:0]           addr_ff;
   logic                       clr_rsp_ff;
   logic [15:0]                count_ff;
   req_word_type               req_ff;
   logic signed [47:0]         bsum_ff;
   logic                       binned_ff;
   logic                       sat_ff;
   logic signed [ACC_BITS-1:0] t_ff;
   logic                       rsp_valid_ff;
   rsp_word_type               rsp_data_ff;

   // memories
   logic [24:0]                weight_mem [MAX_BINS];
   logic signed [ACC_BITS-1:0] snap_mem   [MAX_BINS];
   logic signed [ACC_BITS-1:0] run_mem    [MAX_BINS];
   logic [24:0]                weight_rd_ff;
   logic signed [ACC_BITS-1:0] snap_rd_ff;
   logic signed [ACC_BITS-1:0] run_rd_ff;

   logic                       req_accept;
   logic [SEL_W-1:0]           sel_ext;
   logic                       sel_ok;
   logic                       wgt_we;
   logic                       snap_we;
   logic signed [ACC_BITS-1:0] snap_wd;
   logic                       run_we;
   logic signed [ACC_BITS-1:0] run_wd;
   logic signed [ACC_BITS-1:0] snap_sum;
   logic                       snap_ovf;
   logic signed [ACC_BITS-1:0] run_sum;
   logic                       run_ovf;
   logic                       active;
   logic                       last_addr;
   logic                       out_free;
   logic signed [63:0]         run64;

   // fold and square
   logic [10:0]                half;
   logic [10:0]                ky_u;
   logic signed [11:0]         kx;
   logic signed [11:0]         ky;
   logic signed [23:0]         sqx;
   logic signed [23:0]         sqy;
   logic [R2_W-1:0]            r2;

   logic                       root_done;
   logic [ROOT_W-1:0]          root_bin;
   logic                       bin_ok;

   logic                       sc_start;
   logic signed [ACC_BITS-1:0] sc_a;
   logic [24:0]                sc_f;
   logic                       sc_done;
   logic signed [ACC_BITS-1:0] sc_result;
   logic                       sc_sat;

   always_comb begin
      half = grid_ff >> 1;
      ky_u = 11'(req_ff.row_index) + 11'(offset_ff);
      if ({1'b0, req_ff.col_index} > half) begin
         kx = $signed({2'b00, req_ff.col_index}) - $signed({1'b0, grid_ff});
      end else begin
         kx = $signed({2'b00, req_ff.col_index});
      end
      if (ky_u > half) begin
         ky = $signed({1'b0, ky_u}) - $signed({1'b0, grid_ff});
      end else begin
         ky = $signed({1'b0, ky_u});
      end
      sqx = kx * kx;
      sqy = ky * ky;
      r2  = R2_W'(sqx) + R2_W'(sqy);
   end

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign sel_ext    = SEL_W'(req_word.bin_select);
   assign sel_ok     = (sel_ext < SEL_W'(MAX_BINS));
   assign active     = (SEL_W'(addr_ff) < SEL_W'(bin_count_ff));
   assign last_addr  = (addr_ff == IDX_W'(MAX_BINS - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign bin_ok     = (SEL_W'(root_bin) < SEL_W'(bin_count_ff)) &&
                       (SEL_W'(root_bin) < SEL_W'(MAX_BINS));
   assign run64      = 64'(run_rd_ff);

   always_comb begin
      snap_sum = sat_add(snap_rd_ff, -((ACC_BITS+1)'(req_ff.sample_value)), snap_ovf);
      run_sum  = sat_add(run_rd_ff, (ACC_BITS+1)'(t_ff), run_ovf);
      wgt_we   = req_accept && (req_word.mode == MODE_LOAD_WGT) && sel_ok;
      snap_we  = (state_ff == ST_SADD) || (state_ff == ST_SWWR) || (state_ff == ST_CLR);
      snap_wd  = (state_ff == ST_SADD) ? snap_sum : '0;
      run_we   = ((state_ff == ST_SWWR) && active) || (state_ff == ST_CLR);
      run_wd   = (state_ff == ST_CLR) ? '0 : run_sum;
      sc_start = ((state_ff == ST_SWA) && active) || (state_ff == ST_SWC);
      sc_a     = (state_ff == ST_SWC) ? t_ff : snap_rd_ff;
      sc_f     = (state_ff == ST_SWC) ? weight_rd_ff : inv_scale_ff;
   end

   always_ff @(posedge clock) begin
      if (wgt_we) begin
         weight_mem[sel_ext[IDX_W-1:0]] <= req_word.weight_value;
      end
      weight_rd_ff <= weight_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (snap_we) begin
         snap_mem[addr_ff] <= snap_wd;
      end
      snap_rd_ff <= snap_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (run_we) begin
         run_mem[addr_ff] <= run_wd;
      end
      run_rd_ff <= run_mem[addr_ff];
   end

   rba_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_FOLD),
      .r2    (r2),
      .done  (root_done),
      .bin   (root_bin)
   );

   rba_scale #(
      .ACC_BITS (ACC_BITS)
   ) u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (sc_start),
      .a      (sc_a),
      .f      (sc_f),
      .done   (sc_done),
      .result (sc_result),
      .sat    (sc_sat)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         addr_ff      <= '0;
         clr_rsp_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  req_ff    <= req_word;
                  bsum_ff   <= '0;
                  binned_ff <= 1'b0;
                  sat_ff    <= 1'b0;
                  case (req_word.mode)
                     MODE_SAMPLE: state_ff <= ST_FOLD;
                     MODE_END_SNAP: begin
                        addr_ff  <= '0;
                        state_ff <= ST_SWRD;
                     end
                     MODE_READ: begin
                        addr_ff  <= sel_ext[IDX_W-1:0];
                        state_ff <= sel_ok ? ST_READ1 : ST_RESP;
                     end
                     MODE_CLEAR: begin
                        addr_ff    <= '0;
                        clr_rsp_ff <= 1'b1;
                        count_ff   <= '0;
                        state_ff   <= ST_CLR;
                     end
                     default: state_ff <= ST_RESP;
                  endcase
               end
            end
            ST_FOLD: state_ff <= ST_ROOT;
            ST_ROOT: begin
               if (root_done) begin
                  if (bin_ok) begin
                     binned_ff <= 1'b1;
                     addr_ff   <= root_bin[IDX_W-1:0];
                     state_ff  <= ST_SRD;
                  end else begin
                     state_ff <= ST_RESP;
                  end
               end
            end
            ST_SRD: state_ff <= ST_SADD;
            ST_SADD: begin
               sat_ff   <= sat_ff || snap_ovf;
               state_ff <= ST_RESP;
            end
            ST_SWRD: state_ff <= ST_SWA;
            ST_SWA:  state_ff <= active ? ST_SWB : ST_SWWR;
            ST_SWB: begin
               if (sc_done) begin
                  t_ff     <= sc_result;
                  sat_ff   <= sat_ff || sc_sat;
                  state_ff <= ST_SWC;
               end
            end
            ST_SWC: state_ff <= ST_SWD;
            ST_SWD: begin
               if (sc_done) begin
                  t_ff     <= sc_result;
                  sat_ff   <= sat_ff || sc_sat;
                  state_ff <= ST_SWWR;
               end
            end
            ST_SWWR: begin
               if (active) begin
                  sat_ff <= sat_ff || run_ovf;
               end
               if (last_addr) begin
                  if (count_ff != 16'hFFFF) begin
                     count_ff <= count_ff + 16'd1;
                  end
                  state_ff <= ST_RESP;
               end else begin
                  addr_ff  <= addr_ff + IDX_W'(1);
                  state_ff <= ST_SWRD;
               end
            end
            ST_CLR: begin
               if (last_addr) begin
                  clr_rsp_ff <= 1'b0;
                  state_ff   <= clr_rsp_ff ? ST_RESP : ST_IDLE;
               end else begin
                  addr_ff <= addr_ff + IDX_W'(1);
               end
            end
            ST_READ1: state_ff <= ST_READ2;
            ST_READ2: begin
               if (run64 > OUT_MAX_W) begin
                  bsum_ff <= OUT_MAX_W[47:0];
               end else if (run64 < OUT_MIN_W) begin
                  bsum_ff <= OUT_MIN_W[47:0];
               end else begin
                  bsum_ff <= run64[47:0];
               end
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (out_free) begin
                  rsp_data_ff.bin_sum        <= bsum_ff;
                  rsp_data_ff.snapshot_count <= count_ff;
                  rsp_data_ff.sample_binned  <= binned_ff;
                  rsp_data_ff.saturated      <= sat_ff;
                  rsp_valid_ff               <= 1'b1;
                  state_ff                   <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/rba_checker.sv
// rba_checker: port-level assertions for radial_bin_accumulator, with bind
// uses rba_pkg; attaches to radial_bin_accumulator
`timescale 1ns / 1ps
`default_nettype none
module rba_checker import rba_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_word_type rsp_word
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // clearing pass after reset keeps input stalled
   a_reset_busy: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input not stalled after reset");

   // one word at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input ready right after accept");

   // a binned sample reports no bin sum
   a_binned_no_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.sample_binned |-> rsp_word.bin_sum == 48'sd0)
      else $error("binned sample with nonzero bin sum");

endmodule

bind radial_bin_accumulator rba_checker u_rba_checker (.*);
`default_nettype wire

>>> verif/tb_radial_bin_accumulator.sv
// tb_radial_bin_accumulator: self-checking testbench for radial_bin_accumulator
// depends on rba_pkg and the block's rtl; drives words, predicts every response
// and compares field by field, with random idling on both sides
`timescale 1ns / 1ps
module tb_radial_bin_accumulator;
   import rba_pkg::*;

   localparam int NBINS = 512;
   localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
   localparam longint ACC_LO = -ACC_HI - 1;
   localparam int STALL_LIMIT = 40000;
   localparam logic [2:0] MODE_BAD_LO = 3'd5;
   localparam logic [2:0] MODE_BAD_HI = 3'd7;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall;
   rsp_word_type rsp_word;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic [24:0] csr_wdata;

   radial_bin_accumulator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // model state
   logic [10:0] grid_n;
   logic [9:0] slab_row0;
   logic [24:0] inv_scale;
   logic [9:0] active_req;
   logic [24:0] weights [NBINS];
   longint snap_acc [NBINS];
   longint run_acc [NBINS];
   int unsigned snap_total;

   rsp_word_type pending_rsp [$];
   rsp_word_type typed_q [$];
   bit typed_flag_q [$];
   int errors;
   int words_sent;
   int words_checked;
   int binned_seen;
   int idle_on;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint acc_add(longint a, longint b, ref bit sat);
      if (b > 0 && a > ACC_HI - b) begin
         sat = 1'b1;
         return ACC_HI;
      end
      if (b < 0 && a < ACC_LO - b) begin
         sat = 1'b1;
         return ACC_LO;
      end
      return a + b;
   endfunction

   function automatic longint q24_mul(longint a, logic [24:0] f, ref bit sat);
      bit neg;
      logic [63:0] mag, hi, lo, r, lim;
      neg = a < 0;
      mag = neg ? -a : a;
      hi = (mag >> 32) * {39'd0, f};
      lo = (mag & 64'hFFFF_FFFF) * {39'd0, f};
      lim = neg ? ACC_HI + 1 : ACC_HI;
      if (hi >= (64'd1 << 55)) begin
         sat = 1'b1;
         return neg ? ACC_LO : ACC_HI;
      end
      r = (hi << 8) + ((lo + (64'd1 << 23)) >> 24);
      if (r > lim) begin
         sat = 1'b1;
         return neg ? ACC_LO : ACC_HI;
      end
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic int unsigned root_floor(int unsigned v);
      int unsigned root;
      root = 0;
      for (int b = 12; b >= 0; b--) begin
         if ((root + (1 << b)) * (root + (1 << b)) <= v) root = root + (1 << b);
      end
      return root;
   endfunction

   function automatic int unsigned bins_active();
      return (active_req < NBINS) ? active_req : NBINS;
   endfunction

   function automatic rsp_word_type predict_bins(req_word_type w);
      rsp_word_type o;
      bit sat;
      longint kx, ky, n, t, v;
      int unsigned r2, b;
      o = '0;
      sat = 1'b0;
      case (w.mode)
         MODE_SAMPLE: begin
            n = grid_n;
            kx = w.col_index;
            ky = longint'(w.row_index) + slab_row0;
            if (kx > n / 2) kx -= n;
            if (ky > n / 2) ky -= n;
            r2 = kx * kx + ky * ky;
            b = root_floor(r2);
            if (r2 > b * b + b) b++;
            if (b < bins_active()) begin
               v = w.sample_value;
               snap_acc[b] = acc_add(snap_acc[b], -v, sat);
               o.sample_binned = 1'b1;
            end
         end
         MODE_END_SNAP: begin
            for (int k = 0; k < bins_active(); k++) begin
               t = q24_mul(snap_acc[k], inv_scale, sat);
               t = q24_mul(t, weights[k], sat);
               run_acc[k] = acc_add(run_acc[k], t, sat);
            end
            foreach (snap_acc[k]) snap_acc[k] = 0;
            if (snap_total < 16'hFFFF) snap_total++;
         end
         MODE_READ: o.bin_sum = run_acc[w.bin_select];
         MODE_LOAD_WGT: weights[w.bin_select] = w.weight_value;
         MODE_CLEAR: begin
            foreach (snap_acc[k]) begin
               snap_acc[k] = 0;
               run_acc[k] = 0;
            end
            snap_total = 0;
         end
         default: ;
      endcase
      o.snapshot_count = snap_total;
      o.saturated = sat;
      return o;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d (response %0d)", field, got, want,
               words_checked);
   endtask

   // request acceptance: predict and queue the expected response
   always @(posedge clock) begin
      rsp_word_type p;
      if (!reset && req_valid && !req_stall) begin
         p = predict_bins(req_word);
         if (typed_flag_q.size() != 0 && typed_flag_q.pop_front()) p = typed_q.pop_front();
         pending_rsp.push_back(p);
      end
   end

   // response side: random stall bursts, checking, watchdog
   int stall_left;
   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         quiet_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("** radial_bin_accumulator: FAILED **");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               errors++;
               $display("unexpected response word");
            end else begin
               e = pending_rsp.pop_front();
               if (rsp_word.bin_sum !== e.bin_sum)
                  report_mismatch("bin_sum", rsp_word.bin_sum, e.bin_sum);
               if (rsp_word.snapshot_count !== e.snapshot_count)
                  report_mismatch("snapshot_count", rsp_word.snapshot_count,
                                  e.snapshot_count);
               if (rsp_word.sample_binned !== e.sample_binned)
                  report_mismatch("sample_binned", rsp_word.sample_binned, e.sample_binned);
               if (rsp_word.saturated !== e.saturated)
                  report_mismatch("saturated", rsp_word.saturated, e.saturated);
               if (rsp_word.sample_binned === 1'b1) binned_seen++;
            end
            words_checked++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on != 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // called at a rising edge; returns at the edge where the word is taken
   task automatic send_word(req_word_type w);
      if (idle_on != 0 && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic write_reg(logic [1:0] idx, logic [24:0] val);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CFG_GRID_SIZE: grid_n = val[10:0];
         CFG_ROW_OFFSET: slab_row0 = val[9:0];
         CFG_INV_SCALE: inv_scale = val;
         default: active_req = val[9:0];
      endcase
   endtask

   task automatic send_checked(req_word_type w, bit typed, rsp_word_type t);
      typed_flag_q.push_back(typed);
      if (typed) typed_q.push_back(t);
      send_word(w);
   endtask

   function automatic req_word_type random_word();
      req_word_type w;
      int pick;
      w = '0;
      w.col_index = $urandom;
      w.row_index = $urandom;
      w.sample_value = $urandom;
      w.bin_select = $urandom;
      w.weight_value = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 70) w.mode = MODE_SAMPLE;
      else if (pick < 75) w.mode = MODE_END_SNAP;
      else if (pick < 86) w.mode = MODE_READ;
      else if (pick < 93) w.mode = MODE_LOAD_WGT;
      else if (pick < 95) w.mode = MODE_CLEAR;
      else w.mode = 3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
      // mostly low wavenumbers, near both ends of the axis
      if ($urandom_range(0, 3) != 0) begin
         w.col_index = $urandom_range(0, 1) ? 10'($urandom_range(0, 30))
                                            : 10'(1023 - $urandom_range(0, 30));
         w.row_index = $urandom_range(0, 1) ? 10'($urandom_range(0, 30))
                                            : 10'(1023 - $urandom_range(0, 30));
      end
      case ($urandom_range(0, 9))
         0: w.sample_value = 32'sh7FFF_FFFF;
         1: w.sample_value = 32'sh8000_0000;
         2: w.sample_value = $signed(32'($urandom_range(0, 255))) - 128;
         default: ;
      endcase
      if ($urandom_range(0, 4) == 0) w.weight_value = 25'h100_0000;
      return w;
   endfunction

   typedef struct {
      logic [2:0] mode;
      logic [9:0] col, row;
      logic [31:0] val;
      logic [8:0] sel;
      logic [24:0] wgt;
      bit typed;
      rsp_word_type want;
   } stim_row_type;

   stim_row_type dir_rows [17];
   req_word_type w;

   initial begin
      rsp_word_type z;
      z = '0;
      errors = 0;
      words_sent = 0;
      words_checked = 0;
      binned_seen = 0;
      idle_on = 1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_wr_en = 1'b0;
      csr_index = CFG_GRID_SIZE;
      csr_wdata = '0;
      grid_n = 1024;
      slab_row0 = 0;
      inv_scale = 16384;
      active_req = 512;
      snap_total = 0;
      foreach (snap_acc[k]) begin
         snap_acc[k] = 0;
         run_acc[k] = 0;
         weights[k] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // weights for every bin before any snapshot walks them
      for (int k = 0; k < NBINS; k++) begin
         w = '0;
         w.mode = MODE_LOAD_WGT;
         w.bin_select = k;
         w.weight_value = (k % 7 == 0) ? 25'h1FF_FFFF : 25'($urandom_range(0, 25'h100_0000));
         send_checked(w, 1'b0, z);
      end

      dir_rows[0]  = '{MODE_READ, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0}};
      dir_rows[1]  = '{MODE_READ, 0, 0, 0, 511, 0, 1, '{0, 0, 0, 0}};
      dir_rows[2]  = '{MODE_SAMPLE, 0, 0, 32'h7FFF_FFFF, 0, 0, 1, '{0, 0, 1, 0}};
      dir_rows[3]  = '{MODE_SAMPLE, 1023, 1023, 32'h8000_0000, 0, 0, 1, '{0, 0, 1, 0}};
      dir_rows[4]  = '{MODE_SAMPLE, 512, 0, 1, 0, 0, 1, '{0, 0, 0, 0}};
      dir_rows[5]  = '{MODE_SAMPLE, 300, 400, 32'h0123_4567, 0, 0, 0, z};
      dir_rows[6]  = '{MODE_END_SNAP, 0, 0, 0, 0, 0, 0, z};
      dir_rows[7]  = '{MODE_READ, 0, 0, 0, 0, 0, 0, z};
      dir_rows[8]  = '{MODE_READ, 0, 0, 0, 1, 0, 0, z};
      dir_rows[9]  = '{MODE_BAD_LO, 1023, 1023, 32'hFFFF_FFFF, 511, 25'h1FF_FFFF, 1,
                       '{0, 1, 0, 0}};
      dir_rows[10] = '{MODE_BAD_HI, 0, 0, 0, 0, 0, 1, '{0, 1, 0, 0}};
      dir_rows[11] = '{MODE_LOAD_WGT, 0, 0, 0, 0, 0, 1, '{0, 1, 0, 0}};
      dir_rows[12] = '{MODE_LOAD_WGT, 0, 0, 0, 511, 25'h1FF_FFFF, 1, '{0, 1, 0, 0}};
      dir_rows[13] = '{MODE_SAMPLE, 5, 3, 0, 0, 0, 1, '{0, 1, 1, 0}};
      dir_rows[14] = '{MODE_END_SNAP, 0, 0, 0, 0, 0, 0, z};
      dir_rows[15] = '{MODE_CLEAR, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0}};
      dir_rows[16] = '{MODE_READ, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0}};
      foreach (dir_rows[i]) begin
         w.mode = dir_rows[i].mode;
         w.col_index = dir_rows[i].col;
         w.row_index = dir_rows[i].row;
         w.sample_value = dir_rows[i].val;
         w.bin_select = dir_rows[i].sel;
         w.weight_value = dir_rows[i].wgt;
         send_checked(w, dir_rows[i].typed, dir_rows[i].want);
      end

      // random phases, each under its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               write_reg(CFG_GRID_SIZE, 2);
               write_reg(CFG_ROW_OFFSET, 1023);
               write_reg(CFG_INV_SCALE, 25'h1FF_FFFF);
               write_reg(CFG_BIN_COUNT, 1);
            end
            1: begin
               write_reg(CFG_GRID_SIZE, 11'h7FF);
               write_reg(CFG_ROW_OFFSET, 0);
               write_reg(CFG_INV_SCALE, 0);
               write_reg(CFG_BIN_COUNT, 10'h3FF);
            end
            2: begin
               write_reg(CFG_GRID_SIZE, 0);
               write_reg(CFG_BIN_COUNT, 0);
               write_reg(CFG_INV_SCALE, 25'h100_0000);
            end
            default: begin
               write_reg(CFG_GRID_SIZE, $urandom_range(0, 1) ? 11'd1024
                                                             : 11'($urandom_range(2, 2047)));
               write_reg(CFG_ROW_OFFSET, $urandom_range(0, 1) ? 10'd0 : 10'($urandom));
               write_reg(CFG_INV_SCALE, $urandom_range(0, 1) ? 25'($urandom)
                                                             : 25'($urandom_range(0, 25'h100_0000)));
               write_reg(CFG_BIN_COUNT, $urandom_range(0, 3) != 0
                                        ? 10'($urandom_range(1, 64)) : 10'($urandom));
            end
         endcase
         idle_on = (ph < 7);
         for (int i = 0; i < 34; i++) send_checked(random_word(), 1'b0, z);
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("sent %0d words, checked %0d responses, %0d samples binned",
               words_sent, words_checked, binned_seen);
      $display("covered eight register settings including extremes, with stalls and gaps");
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("** radial_bin_accumulator: PASSED **");
      end else begin
         $display("** radial_bin_accumulator: FAILED **");
      end
      $finish;
   end

endmodule
